// ----- hw/rtl/dwsp_pkg.sv -----
// ----------------------------------------------------------------------------
// dwsp_pkg: shared types and constants for the dual wheel speed controller
// Request formats, register indexes, operation codes and reset values.
// ----------------------------------------------------------------------------
package dwsp_pkg;

	// operation codes of an input request
	typedef enum logic [1:0] {
		OP_EDGE_LEFT  = 2'd0,
		OP_EDGE_RIGHT = 2'd1,
		OP_TICK       = 2'd2,
		OP_NONE       = 2'd3
	} op_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_KP_LEFT      = 3'd0,
		REG_KI_LEFT      = 3'd1,
		REG_KD_LEFT      = 3'd2,
		REG_KP_RIGHT     = 3'd3,
		REG_KI_RIGHT     = 3'd4,
		REG_KD_RIGHT     = 3'd5,
		REG_BALANCE_GAIN = 3'd6,
		REG_PWM_LIMIT    = 3'd7
	} reg_index_t;

	localparam int CFG_DATA_W = 15;

	// register reset values
	localparam logic [11:0] KP_LEFT_RST      = 12'd290;
	localparam logic [11:0] KP_RIGHT_RST     = 12'd300;
	localparam logic [7:0]  BALANCE_GAIN_RST = 8'd10;
	localparam logic [14:0] PWM_LIMIT_RST    = 15'd2000;

	// input request
	typedef struct packed {
		logic [1:0]        operation;
		logic              phase_a;
		logic              phase_b;
		logic signed [7:0] target_left;
		logic signed [7:0] target_right;
		logic              run_enable;
		logic              balance_enable;
		logic              clear_distance;
	} in_item_t;

	// result request
	typedef struct packed {
		logic signed [15:0] pwm_left;
		logic signed [15:0] pwm_right;
		logic signed [15:0] speed_left;
		logic signed [15:0] speed_right;
		logic signed [15:0] distance_left;
		logic signed [15:0] distance_right;
	} out_item_t;

endpackage

// ----- hw/rtl/dual_wheel_speed_pid_top.sv -----
// ----------------------------------------------------------------------------
// dual_wheel_speed_pid_top: two wheel encoder counting and speed PID
// Counts quadrature edges per wheel; a control tick latches speeds, updates
// distances, runs a positional PID per wheel and applies straight-line
// compensation.
// ----------------------------------------------------------------------------
//  channel | signals                      | per request
//  in      | in_valid, in_ready, in_data  | edge or tick, one per cycle unless stalled
//  out     | out_valid, out_ready, out_data | one result per tick
//  cfg     | cfg_we, cfg_index, cfg_data  | register write, no wait
//
//  A request is taken every cycle while the pipe is not stalled.
//  Edges finish in stage 1; a tick's result goes through the product stage
//  register, then the result register, before it is valid.
//  Stage 1 holds the gain multipliers, stage 2 the PID sum, clamp and
//  saturation. A stalled result holds its register; stages behind it
//  keep filling until each is full.
//  Reset clears all counters, PID history and held drive values and loads
//  the default gains.
// ----------------------------------------------------------------------------
module dual_wheel_speed_pid_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  dwsp_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output dwsp_pkg::out_item_t             out_data,
	input  logic                            cfg_we,
	input  logic [2:0]                      cfg_index,
	input  logic [dwsp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dwsp_pkg::*;

	// configuration registers
	logic [11:0] kp_l_q, ki_l_q, kd_l_q, kp_r_q, ki_r_q, kd_r_q;
	logic [7:0]  bal_gain_q;
	logic [14:0] pwm_limit_q;

	// controller state
	logic signed [15:0] cnt_l_q, cnt_r_q, dist_l_q, dist_r_q;
	logic signed [16:0] prev_l_q, prev_r_q;
	logic signed [31:0] sum_l_q, sum_r_q;
	logic signed [15:0] held_l_q, held_r_q;

	// pipeline
	in_item_t           item_s1;
	logic               v_s1, v_s2, out_valid_q;
	out_item_t          out_data_q;
	logic               run_s2, bal_s2;
	logic signed [29:0] prod_p_l_s2, prod_p_r_s2;
	logic signed [44:0] prod_i_l_s2, prod_i_r_s2;
	logic signed [30:0] prod_d_l_s2, prod_d_r_s2;
	logic signed [25:0] comp_s2;
	logic signed [15:0] spd_l_s2, spd_r_s2, dist_l_s2, dist_r_s2;

	// flow control
	logic out_free, s2_free, s1_go, is_tick_s1, differ_s1;

	assign out_free   = !out_valid_q || out_ready;
	assign s2_free    = !v_s2 || out_free;
	assign is_tick_s1 = (op_t'(item_s1.operation) == OP_TICK);
	assign s1_go      = v_s1 && (!is_tick_s1 || s2_free);
	assign in_ready   = !v_s1 || s1_go;
	assign differ_s1  = item_s1.phase_a ^ item_s1.phase_b;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_l_q      <= KP_LEFT_RST;
			ki_l_q      <= '0;
			kd_l_q      <= '0;
			kp_r_q      <= KP_RIGHT_RST;
			ki_r_q      <= '0;
			kd_r_q      <= '0;
			bal_gain_q  <= BALANCE_GAIN_RST;
			pwm_limit_q <= PWM_LIMIT_RST;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_KP_LEFT:      kp_l_q      <= cfg_data[11:0];
				REG_KI_LEFT:      ki_l_q      <= cfg_data[11:0];
				REG_KD_LEFT:      kd_l_q      <= cfg_data[11:0];
				REG_KP_RIGHT:     kp_r_q      <= cfg_data[11:0];
				REG_KI_RIGHT:     ki_r_q      <= cfg_data[11:0];
				REG_KD_RIGHT:     kd_r_q      <= cfg_data[11:0];
				REG_BALANCE_GAIN: bal_gain_q  <= cfg_data[7:0];
				REG_PWM_LIMIT:    pwm_limit_q <= cfg_data[14:0];
				default:          pwm_limit_q <= pwm_limit_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// stage 1: speeds, distances, errors and products
	logic signed [15:0] dist_l_nx, dist_r_nx;
	logic signed [16:0] err_l, err_r;
	logic signed [17:0] derr_l, derr_r;
	logic signed [31:0] sum_l_nx, sum_r_nx;
	logic signed [16:0] dist_diff;

	always_comb begin
		dist_l_nx = item_s1.clear_distance ? '0 : dist_l_q + cnt_l_q;
		dist_r_nx = item_s1.clear_distance ? '0 : dist_r_q + cnt_r_q;
		err_l     = 17'(item_s1.target_left) - 17'(cnt_l_q);
		err_r     = 17'(item_s1.target_right) - 17'(cnt_r_q);
		derr_l    = 18'(err_l) - 18'(prev_l_q);
		derr_r    = 18'(err_r) - 18'(prev_r_q);
		sum_l_nx  = sum_l_q + 32'(err_l);
		sum_r_nx  = sum_r_q + 32'(err_r);
		dist_diff = 17'(dist_l_nx) - 17'(dist_r_nx);
	end

	// counters, distances and PID history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_l_q  <= '0;
			cnt_r_q  <= '0;
			dist_l_q <= '0;
			dist_r_q <= '0;
			prev_l_q <= '0;
			prev_r_q <= '0;
			sum_l_q  <= '0;
			sum_r_q  <= '0;
		end else if (s1_go) begin
			case (op_t'(item_s1.operation))
				OP_EDGE_LEFT: begin
					cnt_l_q <= differ_s1 ? cnt_l_q - 16'sd1 : cnt_l_q + 16'sd1;
				end
				OP_EDGE_RIGHT: begin
					cnt_r_q <= differ_s1 ? cnt_r_q + 16'sd1 : cnt_r_q - 16'sd1;
				end
				OP_TICK: begin
					cnt_l_q  <= '0;
					cnt_r_q  <= '0;
					dist_l_q <= dist_l_nx;
					dist_r_q <= dist_r_nx;
					if (item_s1.run_enable) begin
						prev_l_q <= err_l;
						prev_r_q <= err_r;
						sum_l_q  <= sum_l_nx;
						sum_r_q  <= sum_r_nx;
					end
				end
				default: begin
					cnt_l_q <= cnt_l_q;
				end
			endcase
		end
	end

	// product stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= s1_go && is_tick_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && is_tick_s1) begin
			run_s2      <= item_s1.run_enable;
			bal_s2      <= item_s1.balance_enable;
			prod_p_l_s2 <= 30'($signed({1'b0, kp_l_q})) * 30'(err_l);
			prod_p_r_s2 <= 30'($signed({1'b0, kp_r_q})) * 30'(err_r);
			prod_i_l_s2 <= 45'($signed({1'b0, ki_l_q})) * 45'(sum_l_nx);
			prod_i_r_s2 <= 45'($signed({1'b0, ki_r_q})) * 45'(sum_r_nx);
			prod_d_l_s2 <= 31'($signed({1'b0, kd_l_q})) * 31'(derr_l);
			prod_d_r_s2 <= 31'($signed({1'b0, kd_r_q})) * 31'(derr_r);
			comp_s2     <= 26'($signed({1'b0, bal_gain_q})) * 26'(dist_diff);
			spd_l_s2    <= cnt_l_q;
			spd_r_s2    <= cnt_r_q;
			dist_l_s2   <= dist_l_nx;
			dist_r_s2   <= dist_r_nx;
		end
	end

	// stage 2: PID sum, clamp, compensation and saturation
	logic signed [46:0] pid_l, pid_r, lim_pos, lim_neg;
	logic signed [15:0] clamp_l, clamp_r;
	logic signed [25:0] comp;
	logic signed [27:0] corr_l, corr_r;
	logic signed [15:0] sat_l, sat_r;
	logic signed [15:0] pwm_l, pwm_r;

	always_comb begin
		lim_pos = 47'($signed({1'b0, pwm_limit_q}));
		lim_neg = -lim_pos;
		pid_l   = 47'(prod_p_l_s2) + 47'(prod_i_l_s2) + 47'(prod_d_l_s2);
		pid_r   = 47'(prod_p_r_s2) + 47'(prod_i_r_s2) + 47'(prod_d_r_s2);
		// symmetric clamp to the limit
		if (pid_l > lim_pos) begin
			clamp_l = lim_pos[15:0];
		end else if (pid_l < lim_neg) begin
			clamp_l = lim_neg[15:0];
		end else begin
			clamp_l = pid_l[15:0];
		end
		if (pid_r > lim_pos) begin
			clamp_r = lim_pos[15:0];
		end else if (pid_r < lim_neg) begin
			clamp_r = lim_neg[15:0];
		end else begin
			clamp_r = pid_r[15:0];
		end
		// left subtracts the correction, right adds it
		comp   = bal_s2 ? comp_s2 : '0;
		corr_l = 28'(clamp_l) - 28'(comp);
		corr_r = 28'(clamp_r) + 28'(comp);
		if (corr_l > 28'sd32767) begin
			sat_l = 16'sh7fff;
		end else if (corr_l < -28'sd32768) begin
			sat_l = 16'sh8000;
		end else begin
			sat_l = corr_l[15:0];
		end
		if (corr_r > 28'sd32767) begin
			sat_r = 16'sh7fff;
		end else if (corr_r < -28'sd32768) begin
			sat_r = 16'sh8000;
		end else begin
			sat_r = corr_r[15:0];
		end
		pwm_l = run_s2 ? sat_l : held_l_q;
		pwm_r = run_s2 ? sat_r : held_r_q;
	end

	// held drive values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_l_q <= '0;
			held_r_q <= '0;
		end else if (v_s2 && out_free) begin
			held_l_q <= pwm_l;
			held_r_q <= pwm_r;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && out_free) begin
			out_data_q.pwm_left       <= pwm_l;
			out_data_q.pwm_right      <= pwm_r;
			out_data_q.speed_left     <= spd_l_s2;
			out_data_q.speed_right    <= spd_r_s2;
			out_data_q.distance_left  <= dist_l_s2;
			out_data_q.distance_right <= dist_r_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
